/* src/rpw_pkg.sv */
// ----------------------------------------------------------------------------
// rpw_pkg: shared types and constants of the replay window
// Item structs for both channels, command codes and default window size.
// ----------------------------------------------------------------------------
package rpw_pkg;

	localparam int SEQ_W = 64;
	localparam int ACK_W = 64;
	localparam int WINDOW_BITS_DEF = 128;

	localparam logic [1:0] CMD_CHECK  = 2'd0;
	localparam logic [1:0] CMD_COMMIT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [SEQ_W-1:0] sequence_req;
	} in_item_t;

	typedef struct packed {
		logic             accepted;
		logic             has_packets;
		logic [SEQ_W-1:0] highest_seen;
		logic [ACK_W-1:0] ack_mask;
	} out_item_t;

endpackage

/* src/replay_window_128.sv */
// ----------------------------------------------------------------------------
// replay_window_128: anti-replay sliding window
// Checks and commits 64-bit packet sequence numbers against a bitmap window.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result register is free or being taken
// and returns one result item per item. Items pass through an input register
// and a result register; the window state (started flag, highest sequence,
// WINDOW_BITS-wide bitmap) is updated in the same cycle the result is
// registered, so back-to-back items always see the state left by the one
// before. That combinational state update (64-bit compare and subtract,
// bitmap shift) sets the clock rate. A clear item returns the window to reset
// state.
module replay_window_128 #(
	parameter int WINDOW_BITS = rpw_pkg::WINDOW_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpw_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rpw_pkg::out_item_t out_item
);

	logic                      valid_s1;
	rpw_pkg::in_item_t         item_s1;
	logic                      advance;

	logic                      started_q;
	logic [rpw_pkg::SEQ_W-1:0] top_q;
	logic [WINDOW_BITS-1:0]    bitmap_q;

	logic                      started_nxt;
	logic [rpw_pkg::SEQ_W-1:0] top_nxt;
	logic [WINDOW_BITS-1:0]    bitmap_nxt;
	rpw_pkg::out_item_t        result;

	logic                      out_valid_q;
	rpw_pkg::out_item_t        out_q;

	// result slot frees when empty or being taken
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	rpw_core #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_core (
		.item        (item_s1),
		.started     (started_q),
		.top_seq     (top_q),
		.bitmap      (bitmap_q),
		.started_nxt (started_nxt),
		.top_seq_nxt (top_nxt),
		.bitmap_nxt  (bitmap_nxt),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			top_q       <= '0;
			bitmap_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				started_q <= started_nxt;
				top_q     <= top_nxt;
				bitmap_q  <= bitmap_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	// the top sequence is always marked once anything was committed
	a_top_marked: assert property (@(posedge clk) disable iff (!arst_n)
		bitmap_q[0] == started_q)
		else $error("bitmap bit 0 does not follow started flag");

	// an empty window reports zero fields
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_packets |->
			out_q.highest_seen == '0 && out_q.ack_mask == '0)
		else $error("empty window reports nonzero fields");

	// only a clear item drops the started flag
	a_stop_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		started_q && !started_nxt && valid_s1 && advance |->
			item_s1.cmd == rpw_pkg::CMD_CLEAR)
		else $error("started flag dropped without clear");

	// highest sequence never moves down while started
	a_top_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		started_q && started_nxt && valid_s1 && advance |=> started_q && top_q >= $past(top_q))
		else $error("highest sequence moved down");
`endif

endmodule

/* src/rpw_core.sv */
// ----------------------------------------------------------------------------
// rpw_core: window update logic
// Decides acceptance of one item and computes the next window state and the
// result fields from the current state.
// ----------------------------------------------------------------------------
module rpw_core #(
	parameter int WINDOW_BITS = rpw_pkg::WINDOW_BITS_DEF
) (
	input  rpw_pkg::in_item_t                   item,
	input  logic                                started,
	input  logic [rpw_pkg::SEQ_W-1:0]           top_seq,
	input  logic [WINDOW_BITS-1:0]              bitmap,
	output logic                                started_nxt,
	output logic [rpw_pkg::SEQ_W-1:0]           top_seq_nxt,
	output logic [WINDOW_BITS-1:0]              bitmap_nxt,
	output rpw_pkg::out_item_t                  result
);

	localparam int IDX_W = $clog2(WINDOW_BITS);
	localparam logic [rpw_pkg::SEQ_W-1:0] WIN_SIZE = rpw_pkg::SEQ_W'(WINDOW_BITS);
	localparam logic [WINDOW_BITS-1:0] ONE_BIT = WINDOW_BITS'(1);

	logic [rpw_pkg::SEQ_W-1:0] behind;
	logic [rpw_pkg::SEQ_W-1:0] ahead;
	logic                      above;
	logic                      in_win;
	logic                      ahead_in_win;
	logic [WINDOW_BITS-1:0]    probe;
	logic                      could;
	logic                      ok;

	assign behind       = top_seq - item.sequence_req;
	assign ahead        = item.sequence_req - top_seq;
	assign above        = item.sequence_req > top_seq;
	assign in_win       = behind < WIN_SIZE;
	assign ahead_in_win = ahead < WIN_SIZE;
	assign probe        = bitmap >> behind[IDX_W-1:0];
	assign could        = !started || above || (in_win && !probe[0]);

	always_comb begin
		started_nxt = started;
		top_seq_nxt = top_seq;
		bitmap_nxt  = bitmap;
		ok          = 1'b0;
		case (item.cmd)
			rpw_pkg::CMD_COMMIT: begin
				ok = could;
				if (could) begin
					started_nxt = 1'b1;
					if (!started) begin
						top_seq_nxt = item.sequence_req;
						bitmap_nxt  = ONE_BIT;
					end else if (above) begin
						top_seq_nxt = item.sequence_req;
						// bits shifted past the window top fall off
						if (ahead_in_win) begin
							bitmap_nxt = (bitmap << ahead[IDX_W-1:0]) | ONE_BIT;
						end else begin
							bitmap_nxt = ONE_BIT;
						end
					end else begin
						bitmap_nxt = bitmap | (ONE_BIT << behind[IDX_W-1:0]);
					end
				end
			end
			rpw_pkg::CMD_CLEAR: begin
				started_nxt = 1'b0;
				top_seq_nxt = '0;
				bitmap_nxt  = '0;
			end
			default: begin
				ok = could;
			end
		endcase
	end

	always_comb begin
		result.accepted     = ok;
		result.has_packets  = started_nxt;
		result.highest_seen = started_nxt ? top_seq_nxt : '0;
		result.ack_mask     = started_nxt ? bitmap_nxt[rpw_pkg::ACK_W:1] : '0;
	end

endmodule
